/* src/stereo_to_quad_ramped_gain_mixer_top_assert.svh */
// Assertion macros for the stereo to quad gain mixer.
// Used by sqgm_ctrl and the top level; expects i_clk and i_rst_n in scope.
`ifndef STEREO_TO_QUAD_RAMPED_GAIN_MIXER_TOP_ASSERT_SVH
`define STEREO_TO_QUAD_RAMPED_GAIN_MIXER_TOP_ASSERT_SVH

`define SQGM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SQGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sqgm_pkg.sv */
// Shared types and constants for the stereo to quad gain mixer.
// No dependencies.
package sqgm_pkg;

    localparam int FRAME_SAMPLES_DEF = 160;
    localparam int IDX_W  = 8;
    localparam int SMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int ACC_W  = 32;
    localparam int MUL_W  = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAINS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_MODE   = 8'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SCALE,
        S_RECIP,
        S_GAIN,
        S_MIX,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        t_state            state;
        logic [1:0]        ch;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_ctl;

endpackage

/* src/sqgm_mul.sv */
// Shared unsigned multiplier for the gain mixer datapath.
// Depends on sqgm_pkg for the operand width.
module sqgm_mul (
    input  logic [sqgm_pkg::MUL_W-1:0]   i_a,
    input  logic [sqgm_pkg::MUL_W-1:0]   i_b,
    output logic [2*sqgm_pkg::MUL_W-1:0] o_p
);
    import sqgm_pkg::*;

    assign o_p = 64'(i_a) * 64'(i_b);

endmodule

/* src/sqgm_ctrl.sv */
// Sequencer for the gain mixer: state, channel counter and frame sample index.
// Depends on sqgm_pkg and the assertion macro header.
`include "stereo_to_quad_ramped_gain_mixer_top_assert.svh"

module sqgm_ctrl #(
    parameter int FRAME_SAMPLES = sqgm_pkg::FRAME_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_frame_start,
    input  logic              i_ramp,
    input  logic              i_out_free,
    output sqgm_pkg::t_ctl    o_ctl
);
    import sqgm_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SAMPLES - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_ch, n_ch;
    logic [IDX_W-1:0] r_sidx, n_sidx;
    logic [IDX_W-1:0] idx_eff;
    logic             last;

    always_comb begin
        idx_eff = i_frame_start ? '0 : r_sidx;
        last    = (idx_eff >= LAST_IDX);
        if (last) begin
            idx_eff = LAST_IDX;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_accept) n_state = i_ramp ? S_DIFF : S_GAIN;
            S_DIFF:  n_state = S_SCALE;
            S_SCALE: n_state = S_RECIP;
            S_RECIP: n_state = S_GAIN;
            S_GAIN:  n_state = S_MIX;
            S_MIX:   n_state = S_ACC;
            S_ACC: begin
                if (r_ch == 2'd3) n_state = S_DONE;
                else              n_state = i_ramp ? S_DIFF : S_GAIN;
            end
            S_DONE:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ch   = r_ch;
        n_sidx = r_sidx;
        if (r_state == S_IDLE && i_accept) begin
            n_ch   = 2'd0;
            n_sidx = last ? '0 : idx_eff + 1'b1;
        end else if (r_state == S_ACC) begin
            n_ch = r_ch + 1'b1;
        end
        o_ctl.state = r_state;
        o_ctl.ch    = r_ch;
        o_ctl.idx   = idx_eff;
        o_ctl.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 2'd0;
            r_sidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_sidx  <= n_sidx;
        end
    end

    `SQGM_ASSERT_NOW(a_idle_ch_zero, r_state == S_IDLE, r_ch == 2'd0, "channel not zero in idle")
    `SQGM_ASSERT_NOW(a_sidx_range, 1'b1, r_sidx <= LAST_IDX, "sample index out of frame")
    `SQGM_ASSERT_NEXT(a_frame_restart, r_state == S_IDLE && i_accept && i_frame_start,
                      r_sidx == IDX_W'(1), "frame start did not restart the index")

endmodule

/* src/stereo_to_quad_ramped_gain_mixer_top.sv */
// Top level of the stereo to quad gain mixer: config registers, datapath, output word.
// Depends on sqgm_pkg, sqgm_mul, sqgm_ctrl and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one stereo sample pair, the
//   four bus values and frame_start. Output channel (o_out_valid / i_out_stall)
//   gives the four mixed bus values and frame_last, one word per input word.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write it only
//   while no word is in flight. Index 0 target gains, 1 ramp start gains,
//   2 ramp enable, 3 accumulate mode; other indexes are ignored.
//   One shared 32x32 multiplier serves all four channels in turn. With ramp
//   on, each channel steps through difference, scale by index, reciprocal
//   multiply for the frame division, gain, mix and accumulate; with ramp off,
//   only gain, mix and accumulate. After the last channel the result enters
//   the output register, and the block returns to idle before it takes a new
//   word. While the receiver stalls the output word holds; one finished
//   word may wait there while the next is computed, then the block waits.
//   Reset clears config registers, the sample index and the output valid.
`include "stereo_to_quad_ramped_gain_mixer_top_assert.svh"

module stereo_to_quad_ramped_gain_mixer_top #(
    parameter int FRAME_SAMPLES = sqgm_pkg::FRAME_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [sqgm_pkg::SMP_W-1:0]    i_left_sample,
    input  logic signed [sqgm_pkg::SMP_W-1:0]    i_right_sample,
    input  logic signed [sqgm_pkg::ACC_W-1:0]    i_acc_front_left,
    input  logic signed [sqgm_pkg::ACC_W-1:0]    i_acc_front_right,
    input  logic signed [sqgm_pkg::ACC_W-1:0]    i_acc_rear_left,
    input  logic signed [sqgm_pkg::ACC_W-1:0]    i_acc_rear_right,
    input  logic                                 i_frame_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [sqgm_pkg::ACC_W-1:0]    o_mix_front_left,
    output logic signed [sqgm_pkg::ACC_W-1:0]    o_mix_front_right,
    output logic signed [sqgm_pkg::ACC_W-1:0]    o_mix_rear_left,
    output logic signed [sqgm_pkg::ACC_W-1:0]    o_mix_rear_right,
    output logic                                 o_frame_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sqgm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sqgm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sqgm_pkg::*;

    localparam int unsigned DIV = FRAME_SAMPLES - 1;
    localparam bit DIV_ONE = (DIV == 1);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 32) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [MUL_W-1:0] RECIP = DIV_ONE ? MUL_W'(1) : RECIP_FULL[MUL_W-1:0];

    t_ctl ctl;
    logic accept, out_free;

    logic [CFG_DATA_W-1:0] r_tgt, r_st;
    logic                  r_ramp, r_accum;

    logic [GAIN_W-1:0]     r_smag [2];
    logic                  r_sneg [2];
    logic [ACC_W-1:0]      r_acc  [4];
    logic [ACC_W-1:0]      r_res  [4];
    logic [IDX_W-1:0]      r_idx;
    logic                  r_last;
    logic [GAIN_W-1:0]     r_mag;
    logic                  r_dneg;
    logic [GAIN_W-1:0]     r_gmag;
    logic                  r_pneg;
    logic [2*MUL_W-1:0]    r_prod;
    logic                  r_out_valid;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_p;

    logic [1:0]            ch;
    logic                  sel;
    logic signed [GAIN_W-1:0] tgt, st;
    logic signed [GAIN_W:0]   diff, diff_neg;
    logic [GAIN_W-1:0]     q16;
    logic signed [GAIN_W+1:0] qs, gsum;
    logic signed [GAIN_W-1:0] g16;
    logic signed [GAIN_W:0]   g17, g_neg;
    logic [GAIN_W-1:0]     gmag;
    logic [19:0]           m20;
    logic [ACC_W-1:0]      mixed, res;
    logic signed [SMP_W:0] l17, r17, l_neg, r_neg;

    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (ctl.state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    sqgm_ctrl #(.FRAME_SAMPLES(FRAME_SAMPLES)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_frame_start),
        .i_ramp        (r_ramp),
        .i_out_free    (out_free),
        .o_ctl         (ctl)
    );

    sqgm_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    always_comb begin
        ch  = ctl.ch;
        sel = ch[0];
        tgt = r_tgt[{ch, 4'b0000} +: GAIN_W];
        st  = r_st[{ch, 4'b0000} +: GAIN_W];

        diff     = {tgt[GAIN_W-1], tgt} - {st[GAIN_W-1], st};
        diff_neg = -diff;

        q16  = DIV_ONE ? r_prod[GAIN_W-1:0] : r_prod[MUL_W +: GAIN_W];
        qs   = r_dneg ? -$signed({2'b00, q16}) : $signed({2'b00, q16});
        gsum = {{2{st[GAIN_W-1]}}, st} + qs;
        g16  = r_ramp ? gsum[GAIN_W-1:0] : tgt;
        g17  = {g16[GAIN_W-1], g16};
        g_neg = -g17;
        gmag = g16[GAIN_W-1] ? g_neg[GAIN_W-1:0] : g16;

        m20   = r_prod[31:12];
        mixed = r_pneg ? -{12'b0, m20} : {12'b0, m20};
        res   = mixed + (r_accum ? r_acc[ch] : '0);

        l17   = {i_left_sample[SMP_W-1], i_left_sample};
        r17   = {i_right_sample[SMP_W-1], i_right_sample};
        l_neg = -l17;
        r_neg = -r17;
    end

    always_comb begin
        case (ctl.state)
            S_SCALE: begin
                mul_a = {16'b0, r_mag};
                mul_b = {24'b0, r_idx};
            end
            S_RECIP: begin
                mul_a = {8'b0, r_prod[23:0]};
                mul_b = RECIP;
            end
            default: begin
                mul_a = {16'b0, r_gmag};
                mul_b = {16'b0, r_smag[sel]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt   <= '0;
            r_st    <= '0;
            r_ramp  <= 1'b0;
            r_accum <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_GAINS: r_tgt   <= i_cfg_data;
                CFG_RAMP_START:   r_st    <= i_cfg_data;
                CFG_RAMP_ENABLE:  r_ramp  <= i_cfg_data[0];
                CFG_ACCUM_MODE:   r_accum <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smag[0] <= i_left_sample[SMP_W-1] ? l_neg[SMP_W-1:0] : i_left_sample;
            r_smag[1] <= i_right_sample[SMP_W-1] ? r_neg[SMP_W-1:0] : i_right_sample;
            r_sneg[0] <= i_left_sample[SMP_W-1];
            r_sneg[1] <= i_right_sample[SMP_W-1];
            r_acc[0]  <= i_acc_front_left;
            r_acc[1]  <= i_acc_front_right;
            r_acc[2]  <= i_acc_rear_left;
            r_acc[3]  <= i_acc_rear_right;
            r_idx     <= ctl.idx;
            r_last    <= ctl.last;
        end
        case (ctl.state)
            S_DIFF: begin
                r_dneg <= diff[GAIN_W];
                r_mag  <= diff[GAIN_W] ? diff_neg[GAIN_W-1:0] : diff[GAIN_W-1:0];
            end
            S_SCALE, S_RECIP, S_MIX: r_prod <= mul_p;
            S_GAIN: begin
                r_gmag <= gmag;
                r_pneg <= g16[GAIN_W-1] ^ r_sneg[sel];
            end
            S_ACC: r_res[ch] <= res;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.state == S_DONE && out_free) begin
            o_mix_front_left  <= r_res[0];
            o_mix_front_right <= r_res[1];
            o_mix_rear_left   <= r_res[2];
            o_mix_rear_right  <= r_res[3];
            o_frame_last      <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    `SQGM_ASSERT_NEXT(a_accept_stalls, accept, o_in_stall, "input not stalled after accept")
    `SQGM_ASSERT_NEXT(a_done_loads, ctl.state == S_DONE && out_free, o_out_valid,
                      "finished word not loaded")
    `SQGM_ASSERT_NOW(a_diff_needs_ramp, ctl.state == S_DIFF, r_ramp,
                     "ramp step taken with ramp off")

endmodule
